@@ hw/rtl/sha256_pkg.sv @@
// SHA-256 shared definitions: round constants, initial hash values,
// sequencer state encoding and the round helper functions.
// No dependencies.
`default_nettype none

package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned HashWords = 8;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_FIN   = 7'b0010000,
    ST_ORD   = 7'b0100000,
    ST_OWR   = 7'b1000000
  } state_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] a);
    big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] e);
    big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] w);
    sm_s0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] w);
    sm_s1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha256_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sha256_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sha256_byte_stream_hasher.sv @@
// SHA-256 byte stream hasher top level.
// Depends on sha256_pkg and sha256_ram (message word store, hash word store).
//
// Usage:
//  - Input channel (in_valid/in_stall): each item carries an optional message
//    byte (in_has_byte) and an end flag (in_end_of_message). Bytes are taken
//    one per cycle while the block is collecting.
//  - Result channel (out_valid/out_stall): after each message, eight items with
//    digest words H0..H7, out_word_index 0..7, out_last_word on the eighth.
//  - Throughput: one byte per cycle while filling; a full 64-byte block holds
//    the input while it is loaded, run through 64 rounds at one per cycle,
//    and its working variables are folded back into the hash store. Padding
//    writes one byte per cycle into the block store, so end of message costs
//    the padding plus one or two compressions, then a hash store read and an
//    output load per digest word. The wait from the end item to the first
//    digest word depends on how full the last block was.
//  - The receiver may stall the result channel freely; the last word held in
//    the output register lets the next message start filling meanwhile.
//  - Reset (rst_n low, synchronous) returns the block to collecting an empty
//    message with the standard initial hash; no clearing pass is needed.
`default_nettype none

module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_digest_word,
  output logic      [2:0]  out_word_index,
  output logic             out_last_word
);

  sha256_pkg::state_t state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [23:0] wbuf_r, wbuf_nxt;
  logic [60:0] total_r, total_nxt;
  logic        pend_r, pend_nxt;
  logic        sent80_r, sent80_nxt;
  logic        lenok_r, lenok_nxt;
  logic [7:0]  hv_r, hv_nxt;
  logic        hrv_r;
  logic [2:0]  hri_r;
  logic [31:0] w_r [16];
  logic [31:0] wk_r [8];
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;

  // byte path into the block store
  logic        byte_we;
  logic [7:0]  byte_val;
  logic [63:0] bits;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  // RAM ports
  logic        wram_we, wram_re;
  logic [3:0]  wram_waddr, wram_raddr;
  logic [31:0] wram_wdata, wram_q;
  logic        hram_we, hram_re;
  logic [2:0]  hram_waddr, hram_raddr;
  logic [31:0] hram_wdata, hram_q, hdata;

  // round datapath
  logic [31:0] t1, t2, w_new;
  logic        in_acc, out_load;
  logic        shift_w, shift_wk;

  sha256_ram #(.Width(32), .Depth(sha256_pkg::BlkWords)) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .re    (wram_re),
    .raddr (wram_raddr),
    .rdata (wram_q)
  );

  sha256_ram #(.Width(32), .Depth(sha256_pkg::HashWords)) u_hram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .re    (hram_re),
    .raddr (hram_raddr),
    .rdata (hram_q)
  );

  // hash entries not yet written since reset/digest read as initial values
  assign hdata = hrv_r ? hram_q : sha256_pkg::InitH[hri_r];

  assign in_stall = (state_r != sha256_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign bits     = {total_r, 3'b000};
  assign len_byte = bits[{~fill_r[2:0], 3'b000} +: 8];
  assign pad_byte = !sent80_r ? sha256_pkg::PadByte :
                    (lenok_r && fill_r >= sha256_pkg::LenPos) ? len_byte : 8'h00;

  assign byte_we  = (in_acc && in_has_byte) || (state_r == sha256_pkg::ST_PAD);
  assign byte_val = (state_r == sha256_pkg::ST_PAD) ? pad_byte : in_data_byte;

  assign wram_we    = byte_we && (fill_r[1:0] == 2'b11);
  assign wram_waddr = fill_r[5:2];
  assign wram_wdata = {wbuf_r, byte_val};
  assign wram_re    = (state_r == sha256_pkg::ST_LOAD) && !cnt_r[4];
  assign wram_raddr = cnt_r[3:0];

  assign hram_re    = ((state_r == sha256_pkg::ST_LOAD || state_r == sha256_pkg::ST_FIN) &&
                       cnt_r < 7'd8) || (state_r == sha256_pkg::ST_ORD);
  assign hram_raddr = cnt_r[2:0];
  assign hram_we    = (state_r == sha256_pkg::ST_FIN) && (cnt_r != 7'd0);
  assign hram_waddr = 3'(cnt_r - 7'd1);
  assign hram_wdata = hdata + wk_r[0];

  assign t1 = wk_r[7] + sha256_pkg::big_s1(wk_r[4]) +
              ((wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6])) +
              sha256_pkg::RoundK[cnt_r[5:0]] + w_r[0];
  assign t2 = sha256_pkg::big_s0(wk_r[0]) +
              ((wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]));
  assign w_new = w_r[0] + sha256_pkg::sm_s0(w_r[1]) + w_r[9] + sha256_pkg::sm_s1(w_r[14]);

  assign shift_w  = (state_r == sha256_pkg::ST_LOAD && cnt_r != 7'd0) ||
                    (state_r == sha256_pkg::ST_ROUND);
  assign shift_wk = (state_r == sha256_pkg::ST_LOAD && cnt_r != 7'd0 && cnt_r <= 7'd8) ||
                    (state_r == sha256_pkg::ST_FIN && cnt_r != 7'd0);

  assign out_load = (state_r == sha256_pkg::ST_OWR) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    fill_nxt   = fill_r;
    wbuf_nxt   = wbuf_r;
    total_nxt  = total_r;
    pend_nxt   = pend_r;
    sent80_nxt = sent80_r;
    lenok_nxt  = lenok_r;
    hv_nxt     = hv_r;

    if (byte_we) begin
      wbuf_nxt = {wbuf_r[15:0], byte_val};
      fill_nxt = fill_r + 6'd1;
    end

    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            total_nxt = total_r + 61'd1;
          end
          if (in_has_byte && fill_r == 6'd63) begin
            state_nxt = sha256_pkg::ST_LOAD;
            cnt_nxt   = '0;
            pend_nxt  = in_end_of_message;
          end else if (in_end_of_message) begin
            state_nxt = sha256_pkg::ST_PAD;
            pend_nxt  = 1'b1;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        sent80_nxt = 1'b1;
        // length fits in this block when the marker lands before the length field
        if (!sent80_r && fill_r < sha256_pkg::LenPos) begin
          lenok_nxt = 1'b1;
        end
        if (fill_r == 6'd63) begin
          state_nxt = sha256_pkg::ST_LOAD;
          cnt_nxt   = '0;
        end
      end
      sha256_pkg::ST_LOAD: begin
        if (cnt_r == 7'd16) begin
          state_nxt = sha256_pkg::ST_ROUND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (cnt_r == 7'd63) begin
          state_nxt = sha256_pkg::ST_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      sha256_pkg::ST_FIN: begin
        if (cnt_r != 7'd0) begin
          hv_nxt[hram_waddr] = 1'b1;
        end
        if (cnt_r == 7'd8) begin
          cnt_nxt = '0;
          if (!pend_r) begin
            state_nxt = sha256_pkg::ST_IDLE;
          end else if (lenok_r) begin
            state_nxt = sha256_pkg::ST_ORD;
          end else begin
            // length goes into a second padding block
            state_nxt = sha256_pkg::ST_PAD;
            lenok_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      sha256_pkg::ST_ORD: begin
        state_nxt = sha256_pkg::ST_OWR;
      end
      sha256_pkg::ST_OWR: begin
        if (out_load) begin
          if (cnt_r == 7'd7) begin
            state_nxt  = sha256_pkg::ST_IDLE;
            cnt_nxt    = '0;
            hv_nxt     = '0;
            total_nxt  = '0;
            fill_nxt   = '0;
            pend_nxt   = 1'b0;
            sent80_nxt = 1'b0;
            lenok_nxt  = 1'b0;
          end else begin
            state_nxt = sha256_pkg::ST_ORD;
            cnt_nxt   = cnt_r + 7'd1;
          end
        end
      end
      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      sent80_r    <= 1'b0;
      lenok_r     <= 1'b0;
      hv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      sent80_r    <= sent80_nxt;
      lenok_r     <= lenok_nxt;
      hv_r        <= hv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wbuf_r <= wbuf_nxt;
    if (hram_re) begin
      hrv_r <= hv_r[hram_raddr];
      hri_r <= hram_raddr;
    end
    if (shift_w) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= (state_r == sha256_pkg::ST_ROUND) ? w_new : wram_q;
    end
    if (state_r == sha256_pkg::ST_ROUND) begin
      wk_r[0] <= t1 + t2;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= wk_r[1];
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[5] <= wk_r[4];
      wk_r[6] <= wk_r[5];
      wk_r[7] <= wk_r[6];
    end else if (shift_wk) begin
      for (int i = 0; i < 7; i++) begin
        wk_r[i] <= wk_r[i+1];
      end
      wk_r[7] <= hdata;
    end
    if (out_load) begin
      out_word_r <= hdata;
      out_idx_r  <= cnt_r[2:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == 3'd7);

endmodule

`default_nettype wire

@@ hw/rtl/sha256_chk.sv @@
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher port names only.
`default_nettype none

module sha256_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last_word
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last word flag disagrees with index");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_digest_word) && $stable(out_word_index)))
    else $error("stalled result changed");

endmodule

bind sha256_byte_stream_hasher sha256_chk u_sha256_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);

`default_nettype wire

@@ tb/sha256_byte_stream_hasher_tb.sv @@
// Testbench for sha256_byte_stream_hasher: drives byte items, predicts digests
// with a local SHA-256 model and checks each digest word in order.
// Depends on sha256_pkg (round constants, initial hash values) and the RTL top.
`default_nettype none

module sha256_byte_stream_hasher_tb;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int unsigned err_count = 0;
  bit          hold_off = 1'b0;
  digest_item_t digest_q[$];

  // predictor state
  logic [31:0] h_acc[8];
  logic [7:0]  blk[64];
  logic [60:0] byte_cnt;
  int unsigned fill;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) h_acc[i] = sha256_pkg::InitH[i];
    for (int i = 0; i < 64; i++) blk[i] = '0;
    byte_cnt = '0;
    fill = 0;
  endtask

  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = h_acc[0]; b = h_acc[1]; c = h_acc[2]; d = h_acc[3];
    e = h_acc[4]; f = h_acc[5]; g = h_acc[6]; h = h_acc[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + sha256_pkg::RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h_acc[0] += a; h_acc[1] += b; h_acc[2] += c; h_acc[3] += d;
    h_acc[4] += e; h_acc[5] += f; h_acc[6] += g; h_acc[7] += h;
  endtask

  task automatic predict_item(logic [7:0] data, logic has, logic eom);
    logic [63:0] bits;
    digest_item_t di;
    if (has) begin
      blk[fill] = data;
      fill++;
      byte_cnt = byte_cnt + 61'd1;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (eom) begin
      blk[fill] = sha256_pkg::PadByte;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = '0;
        compress_block();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = '0;
      bits = {byte_cnt, 3'b000};
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        di.word = h_acc[i];
        di.index = 3'(i);
        di.last = (i == 7);
        digest_q.push_back(di);
      end
      hash_restart();
    end
  endtask

  // one item; waits for acceptance, then drops valid for a cycle unless back-to-back
  task automatic send_item(logic [7:0] data, logic has, logic eom, bit keep = 1'b0);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_has_byte <= has;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    predict_item(data, has, eom);
    @(negedge clk);
    if (!keep) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // bursts with random gaps
  task automatic send_random(logic [7:0] data, logic has, logic eom);
    bit burst = ($urandom_range(0, 3) != 0);
    send_item(data, has, eom, burst);
    if (!burst) repeat ($urandom_range(0, 4)) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++)
      send_random(8'($urandom), 1'b1, (i == len - 1));
    if (len == 0) send_random(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b0);          // idle item ignored
    send_item(8'h00, 1'b0, 1'b1);          // empty message
    send_item(8'h61, 1'b1, 1'b0);          // "abc"
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);          // end on item with no byte
    wait_drained();
  endtask

  // lengths around the one/two-final-block boundary and a full block
  task automatic test_block_edges();
    int unsigned lens[4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_message(3);
    send_message(70);
    hold_off = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned sent = 0;
    int unsigned len;
    while (sent < 90) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random(8'($urandom), 1'b0, 1'b0);
        sent++;
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
        send_message(len);
        sent += len + 1;
      end
    end
    wait_drained();
  endtask

  initial begin
    hash_restart();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random();
    if (digest_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver stall pattern, with a long hold-off when asked
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        n = 0;
        while (n < 600) begin
          @(negedge clk);
          n++;
        end
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if ($urandom_range(0, 15) < 4) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    digest_item_t exp_d;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: word %h", out_digest_word);
        err_count++;
      end else begin
        exp_d = digest_q.pop_front();
        if (out_digest_word !== exp_d.word) begin
          $error("digest_word expected %h actual %h", exp_d.word, out_digest_word);
          err_count++;
        end
        if (out_word_index !== exp_d.index) begin
          $error("word_index expected %0d actual %0d", exp_d.index, out_word_index);
          err_count++;
        end
        if (out_last_word !== exp_d.last) begin
          $error("last_word expected %0d actual %0d", exp_d.last, out_last_word);
          err_count++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
